/* hdl/ddo_pkg.sv */
`default_nettype none
package ddo_pkg;

  typedef struct packed {
    logic        load;       // capture input item, start work
    logic        is_pose;
    logic        step_mul;   // speed sums and mid heading
    logic        step_phase; // phase multiply
    logic        step_trig;  // table lookups
    logic        step_prod;  // forward times table entries
    logic        step_upd;   // pose and ring update
    logic        emit;
  } ddo_cmd_t;

  typedef struct packed {
    logic primed;
  } ddo_sts_t;

  localparam logic [1:0] REG_INV_L = 2'd0;
  localparam logic [1:0] REG_INV_R = 2'd1;
  localparam logic [1:0] REG_TPC   = 2'd2;

  localparam logic [31:0] TPC_RESET = 32'd65536;

  // q30 quarter-wave polynomial, as the table generator evaluates it
  function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                     input int unsigned tbits);
    int unsigned qbits;
    int unsigned qsize;
    int unsigned q;
    int unsigned r;
    int unsigned rr;
    longint u;
    longint u2;
    longint t;
    longint s;
    longint e;
    qbits = tbits - 2;
    qsize = 1 << qbits;
    q = (idx >> qbits) & 3;
    r = idx & (qsize - 1);
    rr = ((q & 1) != 0) ? (qsize - r) : r;
    u = longint'(rr) << (32 - tbits);
    u2 = (u * u) >>> 30;
    t = 172273;
    t = 5026995 - ((u2 * t) >>> 30);
    t = 85569306 - ((u2 * t) >>> 30);
    t = 693598668 - ((u2 * t) >>> 30);
    t = 1686629713 - ((u2 * t) >>> 30);
    s = (u * t) >>> 30;
    e = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (e > 32767) e = 32767;
    if (e < 0) e = 0;
    if ((q & 2) != 0) e = -e;
    return e[15:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/ddo_if.sv */
`default_nettype none
interface ddo_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] raw_left;
  logic [15:0] raw_right;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_angle;
  modport source (output valid, command, raw_left, raw_right, pose_x, pose_y, pose_angle,
                  input ready);
  modport sink (input valid, command, raw_left, raw_right, pose_x, pose_y, pose_angle,
                output ready);
endinterface

interface ddo_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [15:0] avg_left;
  logic signed [15:0] avg_right;
  logic signed [15:0] latest_left;
  logic signed [15:0] latest_right;
  modport source (output valid, pos_x, pos_y, heading, avg_left, avg_right, latest_left,
                  latest_right, input ready);
  modport sink (input valid, pos_x, pos_y, heading, avg_left, avg_right, latest_left,
                latest_right, output ready);
endinterface
`default_nettype wire

/* hdl/ddo_ctrl.sv */
`default_nettype none
module ddo_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_command,
  output      logic        in_ready,
  output      logic        out_valid,
  input  wire logic        out_ready,
  input  wire ddo_pkg::ddo_sts_t sts,
  output      ddo_pkg::ddo_cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_TRIG  = 3'd2;
  localparam logic [2:0] S_PROD  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_PHASE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       run_pose;
  logic       run_prime;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      run_pose <= 1'b0;
      run_prime <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        run_pose <= in_command;
        run_prime <= !sts.primed;
      end
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.is_pose = in_command;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (run_pose || run_prime) state_next = S_OUT;
        else begin
          cmd.step_mul = 1'b1;
          state_next = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.step_phase = 1'b1;
        state_next = S_TRIG;
      end
      S_TRIG: begin
        cmd.step_trig = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.step_prod = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.step_upd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/ddo_datapath.sv */
`default_nettype none
module ddo_datapath #(
  parameter int FIFO_DEPTH = 8,
  parameter int TABLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ddo_pkg::ddo_cmd_t cmd,
  output      ddo_pkg::ddo_sts_t sts,
  input  wire logic        inv_l,
  input  wire logic        inv_r,
  input  wire logic [31:0] tpc,
  input  wire logic [15:0] raw_left,
  input  wire logic [15:0] raw_right,
  input  wire logic [31:0] pose_x,
  input  wire logic [31:0] pose_y,
  input  wire logic [31:0] pose_angle,
  output      logic [31:0] pos_x,
  output      logic [31:0] pos_y,
  output      logic [31:0] heading,
  output      logic [15:0] avg_left,
  output      logic [15:0] avg_right,
  output      logic [15:0] latest_left,
  output      logic [15:0] latest_right
);
  localparam int IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int TSIZE = 1 << TABLE_BITS;
  localparam logic [IW-1:0] LAST = IW'(FIFO_DEPTH - 1);

  logic [15:0] prev_l, prev_r;
  logic        primed;
  logic [15:0] ring_l [FIFO_DEPTH];
  logic [15:0] ring_r [FIFO_DEPTH];
  logic [IW-1:0] ridx;
  logic [15:0] av_l, av_r;
  logic [31:0] px, py, ang;
  logic signed [15:0] sl, sr;
  logic signed [16:0] fwd;
  logic [31:0] ang_mid;
  logic [31:0] phase;
  logic signed [15:0] k_cos, k_sin;
  logic signed [32:0] p_cos, p_sin;
  logic signed [15:0] sine_rom [TSIZE];

  always_comb begin
    for (int i = 0; i < TSIZE; i++) sine_rom[i] = ddo_pkg::sine_entry(i, TABLE_BITS);
  end

  logic [15:0] nl, nr;
  assign nl = inv_l ? (16'd0 - raw_left) : raw_left;
  assign nr = inv_r ? (16'd0 - raw_right) : raw_right;

  logic [IW-1:0] nidx;
  assign nidx = (ridx == LAST) ? '0 : ridx + 1'b1;

  logic signed [16:0] rot, half;
  assign rot = 17'(sr) - 17'(sl);
  assign half = (rot < 0) ? -((-rot) >>> 1) : (rot >>> 1);

  logic [31:0] cph;
  assign cph = phase + 32'h4000_0000;

  function automatic logic [15:0] div_d(input logic [15:0] v);
    logic signed [15:0] s;
    s = v;
    return 16'(s / FIFO_DEPTH);
  endfunction

  function automatic logic [31:0] trunc15(input logic signed [32:0] p);
    logic signed [32:0] a;
    a = (p < 0) ? -p : p;
    a = a >>> 15;
    return (p < 0) ? 32'(-a) : 32'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_l <= '0; prev_r <= '0; primed <= 1'b0; ridx <= '0;
      av_l <= '0; av_r <= '0; px <= '0; py <= '0; ang <= '0;
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        ring_l[i] <= '0; ring_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        if (cmd.is_pose) begin
          px <= pose_x; py <= pose_y; ang <= pose_angle;
        end else begin
          primed <= 1'b1;
          prev_l <= nl; prev_r <= nr;
          sl <= nl - prev_l;
          sr <= nr - prev_r;
        end
      end
      if (cmd.step_mul) begin
        fwd <= 17'(sl) + 17'(sr);
        ang_mid <= ang + 32'(half);
      end
      if (cmd.step_phase) begin
        phase <= ang_mid * tpc;
      end
      if (cmd.step_trig) begin
        k_sin <= sine_rom[phase[31 -: TABLE_BITS]];
        k_cos <= sine_rom[cph[31 -: TABLE_BITS]];
      end
      if (cmd.step_prod) begin
        p_cos <= fwd * k_cos;
        p_sin <= fwd * k_sin;
      end
      if (cmd.step_upd) begin
        px <= px + trunc15(p_cos);
        py <= py + trunc15(p_sin);
        ang <= ang_mid + 32'(half);
        ridx <= nidx;
        av_l <= av_l - div_d(ring_l[nidx]) + div_d(sl);
        av_r <= av_r - div_d(ring_r[nidx]) + div_d(sr);
        ring_l[nidx] <= sl;
        ring_r[nidx] <= sr;
      end
    end
  end

  assign sts.primed = primed;
  assign pos_x = px;
  assign pos_y = py;
  assign heading = ang;
  assign avg_left = av_l;
  assign avg_right = av_r;
  assign latest_left = ring_l[ridx];
  assign latest_right = ring_r[ridx];
endmodule
`default_nettype wire

/* hdl/differential_drive_odometry.sv */
`default_nettype none
// Wheel odometry: each input beat is an encoder sample or a set-pose command and yields
// exactly one output beat with the pose, averages and latest speeds after it. For a moving
// sample the work runs in order through speed sums and mid heading, phase multiply, sine
// table read, forward products, and pose and ring update, then output; priming samples and
// set-pose go straight to output. One item is in flight at a time and the next is accepted
// only once the output beat has left.
module differential_drive_odometry #(
  parameter int FIFO_DEPTH = 8,
  parameter int TABLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ddo_in_if.sink           in_ch,
  ddo_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  logic        inv_l, inv_r;
  logic [31:0] tpc;
  ddo_pkg::ddo_cmd_t cmd;
  ddo_pkg::ddo_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_l <= 1'b0; inv_r <= 1'b0; tpc <= ddo_pkg::TPC_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ddo_pkg::REG_INV_L: inv_l <= pwdata[0];
        ddo_pkg::REG_INV_R: inv_r <= pwdata[0];
        ddo_pkg::REG_TPC:   tpc <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ddo_pkg::REG_INV_L: prdata = {31'd0, inv_l};
      ddo_pkg::REG_INV_R: prdata = {31'd0, inv_r};
      ddo_pkg::REG_TPC:   prdata = tpc;
      default:            prdata = '0;
    endcase
  end

  ddo_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_command(in_ch.command), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  ddo_datapath #(.FIFO_DEPTH(FIFO_DEPTH), .TABLE_BITS(TABLE_BITS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .inv_l, .inv_r, .tpc,
    .raw_left(in_ch.raw_left), .raw_right(in_ch.raw_right),
    .pose_x(in_ch.pose_x), .pose_y(in_ch.pose_y), .pose_angle(in_ch.pose_angle),
    .pos_x(out_ch.pos_x), .pos_y(out_ch.pos_y), .heading(out_ch.heading),
    .avg_left(out_ch.avg_left), .avg_right(out_ch.avg_right),
    .latest_left(out_ch.latest_left), .latest_right(out_ch.latest_right)
  );
endmodule
`default_nettype wire

/* sim/differential_drive_odometry_checker.sv */
`timescale 1ns / 100ps
module differential_drive_odometry_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  ddo_in_if.sink           in_mon,
  ddo_out_if.sink          out_mon,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);
  localparam int DEPTH = 8;
  localparam int TBITS = 10;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] hd;
    logic [15:0] al;
    logic [15:0] ar;
    logic [15:0] ll;
    logic [15:0] lr;
  } pose_t;

  logic signed [15:0] sine_lut [0:(1<<TBITS)-1];
  logic        inv_l, inv_r;
  logic [31:0] tpc;
  logic [15:0] last_l, last_r;
  logic        is_primed;
  logic signed [15:0] spd_l [0:DEPTH-1];
  logic signed [15:0] spd_r [0:DEPTH-1];
  int unsigned slot;
  logic [15:0] mean_l, mean_r;
  logic [31:0] odo_x, odo_y, odo_hd;
  pose_t pose_q[$];

  function automatic logic signed [15:0] quarter_entry(int unsigned idx);
    int unsigned q, r, rr;
    longint u, u2, t, s, e;
    q = (idx >> (TBITS - 2)) & 3;
    r = idx & ((1 << (TBITS - 2)) - 1);
    rr = (q & 1) ? ((1 << (TBITS - 2)) - r) : r;
    u = longint'(rr) << (32 - TBITS);
    u2 = (u * u) >>> 30;
    t = 172273;
    t = 5026995 - ((u2 * t) >>> 30);
    t = 85569306 - ((u2 * t) >>> 30);
    t = 693598668 - ((u2 * t) >>> 30);
    t = 1686629713 - ((u2 * t) >>> 30);
    s = (u * t) >>> 30;
    e = (s * 32767 + (longint'(1) << 29)) >>> 30;
    if (e > 32767) e = 32767;
    if (e < 0) e = 0;
    if (q & 2) e = -e;
    return e[15:0];
  endfunction

  function automatic logic [31:0] scale_trunc(int fwd, logic signed [15:0] k);
    longint p;
    p = longint'(fwd) * longint'(k);
    if (p < 0) return 32'(-((-p) >>> 15));
    return 32'(p >>> 15);
  endfunction

  function automatic logic [15:0] mean_adjust(logic [15:0] avg, logic signed [15:0] o,
                                              logic signed [15:0] n);
    int a;
    a = int'($signed(avg)) - int'(o) / DEPTH + int'(n) / DEPTH;
    return a[15:0];
  endfunction

  task automatic odo_advance(logic cmd, logic [15:0] rl, logic [15:0] rr,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] na);
    logic [15:0] nl, nr;
    logic signed [15:0] sl, sr;
    int fwd, rot, half;
    logic [31:0] ph;
    pose_t p;
    if (cmd) begin
      odo_x = nx; odo_y = ny; odo_hd = na;
    end else begin
      nl = inv_l ? 16'(-rl) : rl;
      nr = inv_r ? 16'(-rr) : rr;
      if (!is_primed) begin
        is_primed = 1'b1;
      end else begin
        sl = nl - last_l;
        sr = nr - last_r;
        slot = (slot + 1) % DEPTH;
        mean_l = mean_adjust(mean_l, spd_l[slot], sl);
        mean_r = mean_adjust(mean_r, spd_r[slot], sr);
        spd_l[slot] = sl;
        spd_r[slot] = sr;
        fwd = int'(sl) + int'(sr);
        rot = int'(sr) - int'(sl);
        half = rot / 2;
        odo_hd = odo_hd + 32'(half);
        ph = odo_hd * tpc;
        odo_x = odo_x + scale_trunc(fwd, sine_lut[(ph + 32'h4000_0000) >> (32 - TBITS)]);
        odo_y = odo_y + scale_trunc(fwd, sine_lut[ph >> (32 - TBITS)]);
        odo_hd = odo_hd + 32'(half);
      end
      last_l = nl;
      last_r = nr;
    end
    p.px = odo_x; p.py = odo_y; p.hd = odo_hd; p.al = mean_l; p.ar = mean_r;
    p.ll = spd_l[slot]; p.lr = spd_r[slot];
    pose_q.push_back(p);
  endtask

  initial begin
    for (int i = 0; i < (1 << TBITS); i++) sine_lut[i] = quarter_entry(i);
  end

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      inv_l = 0; inv_r = 0; tpc = ddo_pkg::TPC_RESET;
      last_l = 0; last_r = 0; is_primed = 0; slot = 0;
      mean_l = 0; mean_r = 0; odo_x = 0; odo_y = 0; odo_hd = 0;
      for (int i = 0; i < DEPTH; i++) begin
        spd_l[i] = 0; spd_r[i] = 0;
      end
      pose_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          ddo_pkg::REG_INV_L: inv_l = pwdata[0];
          ddo_pkg::REG_INV_R: inv_r = pwdata[0];
          ddo_pkg::REG_TPC:   tpc = pwdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        odo_advance(in_mon.command, in_mon.raw_left, in_mon.raw_right,
                    in_mon.pose_x, in_mon.pose_y, in_mon.pose_angle);
      if (out_mon.valid && out_mon.ready) begin
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected output beat", $time);
          fail_count <= fail_count + 1;
        end else begin
          e = pose_q.pop_front();
          if (e !== {out_mon.pos_x, out_mon.pos_y, out_mon.heading, out_mon.avg_left,
                     out_mon.avg_right, out_mon.latest_left, out_mon.latest_right}) begin
            $display("%0t: mismatch exp x=%h y=%h hd=%h al=%h ar=%h ll=%h lr=%h", $time,
                     e.px, e.py, e.hd, e.al, e.ar, e.ll, e.lr);
            $display("%0t:          act x=%h y=%h hd=%h al=%h ar=%h ll=%h lr=%h", $time,
                     out_mon.pos_x, out_mon.pos_y, out_mon.heading, out_mon.avg_left,
                     out_mon.avg_right, out_mon.latest_left, out_mon.latest_right);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/differential_drive_odometry_test.sv */
`timescale 1ns / 100ps
module differential_drive_odometry_test;
  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count;
  logic [15:0] enc_l, enc_r;

  ddo_in_if  in_ch();
  ddo_out_if out_ch();

  differential_drive_odometry DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  differential_drive_odometry_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver stalls, with stretches of none
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (cycle_count % 3000 < 500) out_ch.ready <= 1'b1;
      else out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_beat(logic cmd, logic [15:0] rl, logic [15:0] rr,
                           logic [31:0] x, logic [31:0] y, logic [31:0] a, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      @(posedge clk);
      in_ch.valid <= 0;
      repeat (g - 1) @(posedge clk);
    end
    @(posedge clk);
    in_ch.valid <= 1; in_ch.command <= cmd; in_ch.raw_left <= rl; in_ch.raw_right <= rr;
    in_ch.pose_x <= x; in_ch.pose_y <= y; in_ch.pose_angle <= a;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 0;
  endtask

  task automatic send_sample(logic [15:0] dl, logic [15:0] dr, bit gaps);
    enc_l += dl; enc_r += dr;
    send_beat(1'b0, enc_l, enc_r, $urandom, $urandom, $urandom, gaps);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) send_beat(1'b1, 16'($urandom), 16'($urandom), $urandom, $urandom,
                           $urandom, 1);
      else if (k < 15) begin
        enc_l = 16'($urandom); enc_r = 16'($urandom);
        send_beat(1'b0, enc_l, enc_r, $urandom, $urandom, $urandom, 1);
      end else if (k < 60) send_sample(16'($signed($urandom_range(0, 400)) - 200),
                                      16'($signed($urandom_range(0, 400)) - 200), 1);
      else send_sample(16'($urandom), 16'($urandom), 1);
    end
  endtask

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0; in_ch.command = 0; in_ch.raw_left = 0; in_ch.raw_right = 0;
    in_ch.pose_x = 0; in_ch.pose_y = 0; in_ch.pose_angle = 0;
    enc_l = 0; enc_r = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // priming sample, then extremes of wrap-around
    send_sample(16'h0000, 16'hffff, 0);
    send_sample(16'h7fff, 16'h8000, 0);
    send_sample(16'h8000, 16'h7fff, 0);
    send_sample(16'hffff, 16'h0001, 0);
    send_beat(1'b1, 16'hffff, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send_sample(16'h0100, 16'h0100, 0);
    send_sample(16'h0000, 16'h0200, 0);
    send_beat(1'b1, 16'd0, 16'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    for (int i = 0; i < 10; i++) send_sample(16'h7fff, 16'h7fff, 0);
    send_sample(16'h8001, 16'h0007, 0);
    send_sample(16'h0007, 16'hfff9, 0);
    drain();

    reg_write(ddo_pkg::REG_INV_L, 1);
    reg_write(ddo_pkg::REG_TPC, 32'hffffffff);
    random_phase(150);
    drain();
    reg_write(ddo_pkg::REG_INV_L, 0);
    reg_write(ddo_pkg::REG_INV_R, 1);
    reg_write(ddo_pkg::REG_TPC, 0);
    random_phase(150);
    drain();
    reg_write(ddo_pkg::REG_INV_L, 1);
    reg_write(ddo_pkg::REG_TPC, $urandom);
    random_phase(150);
    drain();
    reg_write(ddo_pkg::REG_INV_L, 0);
    reg_write(ddo_pkg::REG_INV_R, 0);
    reg_write(ddo_pkg::REG_TPC, 32'h0100_0000);
    random_phase(150);
    drain();
    reg_write(ddo_pkg::REG_TPC, ddo_pkg::TPC_RESET);
    random_phase(150);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
